// ===== rtl/core/ptac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptac_pkg;

   // Field widths of the process table.
   localparam int unsigned ID_W     = 32;
   localparam int unsigned OWNER_W  = 32;
   localparam int unsigned LEVEL_W  = 2;
   localparam int unsigned TAG_W    = 52;

   // Default table depth.
   localparam int unsigned TABLE_ENTRIES_DEFAULT = 32;

   // Reset values of the id counter and the privileged level register.
   localparam logic [ID_W-1:0]    NEXT_ID_RESET = ID_W'(1);
   localparam logic [LEVEL_W-1:0] PRIV_RESET    = LEVEL_W'(3);

   // Opcodes of a request.
   localparam logic OP_CREATE   = 1'b0;
   localparam logic OP_VALIDATE = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_DENIED    = 2'd3
   } status_type;

   // One stored process entry.
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [OWNER_W-1:0] owner;
      logic [LEVEL_W-1:0] level;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic ready;
      logic scan_step;
      logic scan_read;
      logic create_commit;
      logic create_full;
      logic val_decide;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_valid;
      logic req_opcode;
      logic slot_free;
      logic scan_last;
      logic out_free;
   } dp_status_type;

   // Isolation tag: id shifted by 20, xor owner shifted by 8, xor level.
   function automatic logic [TAG_W-1:0] make_tag(input logic [ID_W-1:0] id,
                                                 input logic [OWNER_W-1:0] owner,
                                                 input logic [LEVEL_W-1:0] level);
      logic [TAG_W-1:0] tag;
      tag = {id, 20'b0} ^ {12'b0, owner, 8'b0} ^ {50'b0, level};
      return tag;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ptac_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one create or validate item per transfer.
interface ptac_req_if;
   import ptac_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [OWNER_W-1:0]   owner_id;
   logic [LEVEL_W-1:0]   level;
   logic [ID_W-1:0]      caller_id;
   logic [ID_W-1:0]      target_id;

   modport source (output valid, opcode, owner_id, level, caller_id, target_id,
                   input ready);
   modport sink   (input valid, opcode, owner_id, level, caller_id, target_id,
                   output ready);
endinterface

// Response channel: one result per request.
interface ptac_rsp_if;
   import ptac_pkg::*;

   logic              valid;
   logic              ready;
   status_type        status;
   logic [ID_W-1:0]   new_id;
   logic [TAG_W-1:0]  proc_tag;

   modport source (output valid, status, new_id, proc_tag, input ready);
   modport sink   (input valid, status, new_id, proc_tag, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ptac_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptac_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  ptac_pkg::dp_status_type     status_in,
   output ptac_pkg::ctrl_cmd_type      cmd_out
);
   import ptac_pkg::*;

   typedef enum logic [5:0] {
      IDLE        = 6'b000001,
      CREATE_SCAN = 6'b000010,
      VAL_SCAN    = 6'b000100,
      VAL_DRAIN   = 6'b001000,
      VAL_DECIDE  = 6'b010000,
      FINISH      = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd_out  = '0;
      unique case (state_ff)
         IDLE: begin
            cmd_out.ready = 1'b1;
            if (status_in.req_valid) begin
               state_in = (status_in.req_opcode == OP_CREATE) ? CREATE_SCAN : VAL_SCAN;
            end
         end
         CREATE_SCAN: begin
            if (status_in.slot_free) begin
               cmd_out.create_commit = 1'b1;
               state_in = FINISH;
            end else if (status_in.scan_last) begin
               cmd_out.create_full = 1'b1;
               state_in = FINISH;
            end else begin
               cmd_out.scan_step = 1'b1;
            end
         end
         VAL_SCAN: begin
            cmd_out.scan_read = 1'b1;
            if (status_in.scan_last) begin
               state_in = VAL_DRAIN;
            end else begin
               cmd_out.scan_step = 1'b1;
            end
         end
         VAL_DRAIN: begin
            state_in = VAL_DECIDE;
         end
         VAL_DECIDE: begin
            cmd_out.val_decide = 1'b1;
            state_in = FINISH;
         end
         FINISH: begin
            if (status_in.out_free) begin
               cmd_out.load_rsp = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ptac_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptac_datapath #(
   parameter int unsigned TABLE_ENTRIES = ptac_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ptac_req_if.sink                         req_port,
   ptac_rsp_if.source                       rsp_port,
   input  wire logic                        csr_we,
   input  wire logic [ptac_pkg::LEVEL_W-1:0] csr_wdata,
   input  ptac_pkg::ctrl_cmd_type           cmd_in,
   output ptac_pkg::dp_status_type          status_out
);
   import ptac_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // Captured request.
   logic [OWNER_W-1:0] owner_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [ID_W-1:0]    caller_ff;
   logic [ID_W-1:0]    target_ff;

   // Table: valid bits in flip-flops, entry contents in a memory.
   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type                table_mem_ff [TABLE_ENTRIES];
   entry_type                rd_q_ff;
   logic                     rd_en_ff;
   logic                     rd_vld_ff;

   logic [IDX_W-1:0]   idx_ff;
   logic [ID_W-1:0]    next_id_ff;
   logic [LEVEL_W-1:0] priv_ff;

   // Lookup results for caller and target.
   logic               c_found_ff;
   logic               t_found_ff;
   logic [OWNER_W-1:0] c_owner_ff;
   logic [OWNER_W-1:0] t_owner_ff;
   logic [LEVEL_W-1:0] c_level_ff;
   logic [LEVEL_W-1:0] t_level_ff;

   // Pending result and output register.
   status_type         res_status_ff;
   logic [ID_W-1:0]    res_nid_ff;
   logic [TAG_W-1:0]   res_tag_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ID_W-1:0]    rsp_nid_ff;
   logic [TAG_W-1:0]   rsp_tag_ff;

   logic               capture;
   entry_type          new_entry;
   status_type         val_status;

   assign capture = req_port.valid && cmd_in.ready;
   assign req_port.ready = cmd_in.ready;

   assign new_entry.id    = next_id_ff;
   assign new_entry.owner = owner_ff;
   assign new_entry.level = level_ff;

   // Status towards the controller.
   assign status_out.req_valid  = req_port.valid;
   assign status_out.req_opcode = req_port.opcode;
   assign status_out.slot_free  = !valid_ff[idx_ff];
   assign status_out.scan_last  = (idx_ff == LAST_IDX);
   assign status_out.out_free   = !rsp_valid_ff || rsp_port.ready;

   // Request capture; the scan index restarts with every item.
   always_ff @(posedge clock) begin
      if (capture) begin
         owner_ff  <= req_port.owner_id;
         level_ff  <= req_port.level;
         caller_ff <= req_port.caller_id;
         target_ff <= req_port.target_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (capture) begin
         idx_ff <= '0;
      end else if (cmd_in.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Privileged level register.
   always_ff @(posedge clock) begin
      if (reset) begin
         priv_ff <= PRIV_RESET;
      end else if (csr_we) begin
         priv_ff <= csr_wdata;
      end
   end

   // Valid bits and the id counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         next_id_ff <= NEXT_ID_RESET;
      end else if (cmd_in.create_commit) begin
         valid_ff[idx_ff] <= 1'b1;
         next_id_ff       <= next_id_ff + 1'b1;
      end
   end

   // Entry memory: written on create, read one entry a cycle during a lookup.
   always_ff @(posedge clock) begin
      if (cmd_in.create_commit) begin
         table_mem_ff[idx_ff] <= new_entry;
      end
      if (cmd_in.scan_read) begin
         rd_q_ff   <= table_mem_ff[idx_ff];
         rd_vld_ff <= valid_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_en_ff <= 1'b0;
      end else begin
         rd_en_ff <= cmd_in.scan_read;
      end
   end

   // Compare stage. Entries arrive in rising index order, so the last hit
   // is the highest matching entry.
   always_ff @(posedge clock) begin
      if (capture) begin
         c_found_ff <= 1'b0;
         t_found_ff <= 1'b0;
      end else if (rd_en_ff && rd_vld_ff) begin
         if (rd_q_ff.id == caller_ff) begin
            c_found_ff <= 1'b1;
            c_owner_ff <= rd_q_ff.owner;
            c_level_ff <= rd_q_ff.level;
         end
         if (rd_q_ff.id == target_ff) begin
            t_found_ff <= 1'b1;
            t_owner_ff <= rd_q_ff.owner;
            t_level_ff <= rd_q_ff.level;
         end
      end
   end

   // Access decision once both lookups are complete.
   always_comb begin
      if (!c_found_ff || !t_found_ff) begin
         val_status = STATUS_NOT_FOUND;
      end else if (caller_ff == target_ff) begin
         val_status = STATUS_OK;
      end else if (c_level_ff >= priv_ff) begin
         val_status = STATUS_OK;
      end else if ((c_owner_ff == t_owner_ff) && (c_level_ff >= t_level_ff)) begin
         val_status = STATUS_OK;
      end else begin
         val_status = STATUS_DENIED;
      end
   end

   // Pending result of the item in progress.
   always_ff @(posedge clock) begin
      if (cmd_in.create_commit) begin
         res_status_ff <= STATUS_OK;
         res_nid_ff    <= next_id_ff;
         res_tag_ff    <= make_tag(next_id_ff, owner_ff, level_ff);
      end else if (cmd_in.create_full) begin
         res_status_ff <= STATUS_FULL;
         res_nid_ff    <= '0;
         res_tag_ff    <= '0;
      end else if (cmd_in.val_decide) begin
         res_status_ff <= val_status;
         res_nid_ff    <= '0;
         res_tag_ff    <= '0;
      end
   end

   // Output register; a new request may be taken while a result waits here.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_in.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_in.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_nid_ff    <= res_nid_ff;
         rsp_tag_ff    <= res_tag_ff;
      end
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.status   = rsp_status_ff;
   assign rsp_port.new_id   = rsp_nid_ff;
   assign rsp_port.proc_tag = rsp_tag_ff;

endmodule

`default_nettype wire

// ===== rtl/core/process_table_access_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Process table access checker. The block keeps TABLE_ENTRIES process entries
// and handles one request at a time, returning exactly one result per request
// transfer. A create request fills the lowest free entry with the next id from
// a 32-bit counter (reset to one, wrapping) and returns the id and its
// isolation tag, or status full. A validate request looks up caller and target
// by id (the highest matching entry wins) and returns granted, not found or
// denied. Timing is set by a sequential scan of the table in index order, one
// entry per cycle: a create tests the valid bits and stops at the lowest free
// entry, and a validate reads every entry through the single read port of the
// entry memory. The result sits in an output register, so the next request is
// taken while it waits. Valid bits are cleared at reset directly, so no
// clearing pass is needed. The privileged level register (reset 3) is written
// through csr_we and csr_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module process_table_access_checker #(
   parameter int unsigned TABLE_ENTRIES = ptac_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ptac_req_if.sink                          req_port,
   ptac_rsp_if.source                        rsp_port,
   input  wire logic                         csr_we,
   input  wire logic [ptac_pkg::LEVEL_W-1:0] csr_wdata
);
   import ptac_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Sequencer.
   ptac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status_in (dp_status),
      .cmd_out   (cmd)
   );

   // Table, lookup and result registers.
   ptac_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .rsp_port   (rsp_port),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd_in     (cmd),
      .status_out (dp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ptac_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptac_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [1:0]                    rsp_status,
   input wire logic [ptac_pkg::ID_W-1:0]     rsp_new_id,
   input wire logic [ptac_pkg::TAG_W-1:0]    rsp_tag
);
   import ptac_pkg::*;

   // A waiting result stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // Only one request is in progress: ready drops after every request transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // Full, not found and denied results carry neither id nor tag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_new_id == '0) && (rsp_tag == '0))
      else $error("failed result carries an id or a tag");

   // Tag bits between the level and the owner field are always clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tag[7:2] == '0))
      else $error("isolation tag has stray low bits");

endmodule

bind process_table_access_checker ptac_checker u_ptac_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_status (rsp_port.status),
   .rsp_new_id (rsp_port.new_id),
   .rsp_tag    (rsp_port.proc_tag)
);

`default_nettype wire

// ===== bench/tb_process_table_access_checker.sv =====
`timescale 1ns / 1ps

module tb_process_table_access_checker;
   import ptac_pkg::*;

   localparam int unsigned ENTRIES     = TABLE_ENTRIES_DEFAULT;
   localparam int unsigned PHASE_ITEMS = 190;
   localparam int unsigned PHASES      = 5;
   localparam int unsigned DRAIN_WAIT  = ENTRIES + 8;
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned NUM_ROWS    = 18;

   // One request as it crosses the request channel.
   typedef struct packed {
      logic               opcode;
      logic [OWNER_W-1:0] owner_id;
      logic [LEVEL_W-1:0] level;
      logic [ID_W-1:0]    caller_id;
      logic [ID_W-1:0]    target_id;
   } request_type;

   // One result as it crosses the response channel.
   typedef struct packed {
      status_type         status;
      logic [ID_W-1:0]    new_id;
      logic [TAG_W-1:0]   proc_tag;
   } outcome_type;

   // A directed row; the outcome is used only where it is typed in.
   typedef struct packed {
      request_type        req;
      logic               typed;
      outcome_type        want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [LEVEL_W-1:0] csr_wdata;

   ptac_req_if req_bus ();
   ptac_rsp_if rsp_bus ();

   process_table_access_checker uut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the process table and the privileged level register.
   logic               shadow_valid [ENTRIES];
   logic [ID_W-1:0]    shadow_id    [ENTRIES];
   logic [OWNER_W-1:0] shadow_owner [ENTRIES];
   logic [LEVEL_W-1:0] shadow_level [ENTRIES];
   logic [ID_W-1:0]    shadow_next_id;
   logic [LEVEL_W-1:0] shadow_priv;

   outcome_type pending_outcomes [$];
   logic [OWNER_W-1:0] owner_pool [4];
   int unsigned fault_count;
   int unsigned results_seen;
   int unsigned quiet_cycles;
   logic        calm;

   // Directed rows: empty table first, then a small family of processes.
   // Ids handed out: 1 (owner 0, level 0), 2 (all-ones owner, level 3),
   // 3 (owner 0, level 1), 4 (owner 0, level 2), 5 (owner AAAAAAAA, level 1).
   directed_row_type directed_rows [NUM_ROWS] = '{
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd1, 32'd1}, 1'b1,
        '{STATUS_NOT_FOUND, 32'd0, 52'd0}},
      '{'{OP_CREATE, 32'h0, 2'd0, 32'd0, 32'd0}, 1'b1,
        '{STATUS_OK, 32'd1, 52'h0000000100000}},
      '{'{OP_CREATE, 32'hFFFF_FFFF, 2'd3, 32'd0, 32'd0}, 1'b0,
        '{STATUS_OK, 32'd0, 52'd0}},
      '{'{OP_CREATE, 32'h0, 2'd1, 32'd0, 32'd0}, 1'b0,
        '{STATUS_OK, 32'd0, 52'd0}},
      '{'{OP_CREATE, 32'h0, 2'd2, 32'd0, 32'd0}, 1'b0,
        '{STATUS_OK, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd1, 32'd1}, 1'b1,
        '{STATUS_OK, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd3, 32'd4}, 1'b1,
        '{STATUS_DENIED, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd4, 32'd3}, 1'b1,
        '{STATUS_OK, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd3, 32'd1}, 1'b1,
        '{STATUS_OK, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd2, 32'd1}, 1'b1,
        '{STATUS_OK, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd1, 32'd2}, 1'b1,
        '{STATUS_DENIED, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd1, 32'hFFFF_FFFF}, 1'b1,
        '{STATUS_NOT_FOUND, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'hFFFF_FFFF, 32'd1}, 1'b1,
        '{STATUS_NOT_FOUND, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd0, 32'd0}, 1'b1,
        '{STATUS_NOT_FOUND, 32'd0, 52'd0}},
      '{'{OP_CREATE, 32'hAAAA_AAAA, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0,
        '{STATUS_OK, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'hFFFF_FFFF, 2'd3, 32'd5, 32'd5}, 1'b1,
        '{STATUS_OK, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd5, 32'd3}, 1'b1,
        '{STATUS_DENIED, 32'd0, 52'd0}},
      '{'{OP_VALIDATE, 32'h0, 2'd0, 32'd2, 32'd5}, 1'b1,
        '{STATUS_OK, 32'd0, 52'd0}}
   };

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Highest-index live entry holding this id, or -1.
   function automatic int lookup_process(input logic [ID_W-1:0] id);
      int hit;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (shadow_valid[i] && shadow_id[i] == id) begin
            hit = i;
         end
      end
      return hit;
   endfunction

   // Lowest free entry, or -1 when the table is full.
   function automatic int free_slot();
      for (int i = 0; i < ENTRIES; i++) begin
         if (!shadow_valid[i]) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Works out the result of one accepted request and updates the shadow table.
   task automatic decide_access(input request_type r, output outcome_type res);
      int slot;
      int c;
      int t;
      res = '{STATUS_OK, '0, '0};
      if (r.opcode == OP_CREATE) begin
         slot = free_slot();
         if (slot < 0) begin
            res.status = STATUS_FULL;
         end else begin
            shadow_valid[slot] = 1'b1;
            shadow_id[slot]    = shadow_next_id;
            shadow_owner[slot] = r.owner_id;
            shadow_level[slot] = r.level;
            res.new_id         = shadow_next_id;
            res.proc_tag       = (TAG_W'(shadow_next_id) << 20) ^
                                 (TAG_W'(r.owner_id) << 8) ^ TAG_W'(r.level);
            shadow_next_id     = shadow_next_id + 1'b1;
         end
      end else begin
         c = lookup_process(r.caller_id);
         t = lookup_process(r.target_id);
         if (c < 0 || t < 0) begin
            res.status = STATUS_NOT_FOUND;
         end else if (shadow_id[c] == shadow_id[t]) begin
            res.status = STATUS_OK;
         end else if (shadow_level[c] >= shadow_priv) begin
            res.status = STATUS_OK;
         end else if (shadow_owner[c] == shadow_owner[t] &&
                      shadow_level[c] >= shadow_level[t]) begin
            res.status = STATUS_OK;
         end else begin
            res.status = STATUS_DENIED;
         end
      end
   endtask

   // Presents one request, holds it until the transfer, and records the
   // outcome. Entered and left just after a falling edge.
   task automatic send_request(input request_type r, input logic typed,
                               input outcome_type want);
      outcome_type predicted;
      logic        taken;
      if (!calm && $urandom_range(99) < 27) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 27);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= r.opcode;
      req_bus.owner_id  <= r.owner_id;
      req_bus.level     <= r.level;
      req_bus.caller_id <= r.caller_id;
      req_bus.target_id <= r.target_id;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_bus.ready;
      end
      decide_access(r, predicted);
      pending_outcomes.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Drops valid and waits until every outstanding result has been taken.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Writes the privileged level while the block is idle.
   task automatic write_privileged_level(input logic [LEVEL_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      shadow_priv = value;
   endtask

   // Mostly ids that are live, sometimes ones that cannot exist.
   function automatic logic [ID_W-1:0] pick_process_id();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70 && shadow_next_id > 1) begin
         return $urandom_range(shadow_next_id - 1, 1);
      end else if (roll < 80) begin
         return ($urandom_range(1) != 0) ? shadow_next_id : '0;
      end
      return $urandom();
   endfunction

   // Random request: mostly validates, with creates more likely while an entry is free.
   function automatic request_type random_request();
      request_type r;
      int unsigned create_odds;
      create_odds = (free_slot() >= 0) ? 15 : 6;
      r.opcode    = ($urandom_range(99) < create_odds) ? OP_CREATE : OP_VALIDATE;
      r.owner_id  = ($urandom_range(99) < 80) ? owner_pool[2'($urandom_range(3))]
                                               : $urandom();
      r.level     = LEVEL_W'($urandom_range(3));
      r.caller_id = $urandom();
      r.target_id = $urandom();
      if (r.opcode == OP_VALIDATE) begin
         r.caller_id = pick_process_id();
         r.target_id = ($urandom_range(99) < 10) ? r.caller_id : pick_process_id();
      end
      return r;
   endfunction

   // Response side stalls at random except during the calm phase.
   always @(negedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= 27);
   end

   // Compares each result transfer with the oldest outstanding outcome.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("Result %0d arrived with nothing outstanding", results_seen);
            end
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.new_id !== want.new_id ||
                rsp_bus.proc_tag !== want.proc_tag) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("Result %0d: status %0d/%0d new_id %h/%h tag %h/%h",
                           results_seen, want.status, rsp_bus.status,
                           want.new_id, rsp_bus.new_id,
                           want.proc_tag, rsp_bus.proc_tag);
                  $display("   (values shown as expected/actual)");
               end
            end
         end
      end
   end

   // Ends the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Main sequence: reset, directed rows, then random phases with
   // different privileged levels.
   initial begin
      logic [LEVEL_W-1:0] phase_priv [PHASES];
      phase_priv = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd0};
      fault_count   = 0;
      results_seen  = 0;
      quiet_cycles  = 0;
      calm          = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = OP_CREATE;
      req_bus.owner_id  = '0;
      req_bus.level     = '0;
      req_bus.caller_id = '0;
      req_bus.target_id = '0;
      rsp_bus.ready     = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_id[i]    = '0;
         shadow_owner[i] = '0;
         shadow_level[i] = '0;
      end
      shadow_next_id = NEXT_ID_RESET;
      shadow_priv    = PRIV_RESET;
      owner_pool = '{32'h0, 32'hFFFF_FFFF, $urandom(), $urandom()};

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].typed,
                      directed_rows[i].want);
      end
      drain_results();

      // Each phase starts from an idle block with a fresh privileged level;
      // the middle phase runs without any idling on either side.
      for (int p = 0; p < PHASES; p++) begin
         write_privileged_level(phase_priv[p]);
         calm = (p == 2);
         repeat (PHASE_ITEMS) begin
            send_request(random_request(), 1'b0, '0);
         end
         drain_results();
      end
      calm = 1'b0;

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fault_count == 0 && pending_outcomes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
